// ===== sv/skts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_pkg
// shared sizes, command codes and controller/datapath link types
// ----------------------------------------------------------------------------
package skts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int WORD_W      = 56;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_SORT   = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        WA_COUNT = 2'd0,
        WA_A     = 2'd1,
        WA_B     = 2'd2
    } waddr_sel_t;

    typedef enum logic {
        WD_IN   = 1'b0,
        WD_AREG = 1'b1
    } wdata_sel_t;

    typedef enum logic [1:0] {
        RA_A   = 2'd0,
        RA_B   = 2'd1,
        RA_BP1 = 2'd2,
        RA_MID = 2'd3
    } raddr_sel_t;

    typedef enum logic [1:0] {
        A_HOLD  = 2'd0,
        A_ZERO  = 2'd1,
        A_INC   = 2'd2,
        A_MIDP1 = 2'd3
    } a_op_t;

    typedef enum logic [2:0] {
        B_HOLD  = 3'd0,
        B_COUNT = 3'd1,
        B_AP1   = 3'd2,
        B_INC   = 3'd3,
        B_MID   = 3'd4
    } b_op_t;

    typedef enum logic [1:0] {
        EMIT_LIST = 2'd0,
        EMIT_HIT  = 2'd1,
        EMIT_MISS = 2'd2
    } emit_sel_t;

    typedef struct packed {
        logic       mem_we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        raddr_sel_t raddr_sel;
        logic       cnt_inc;
        a_op_t      a_op;
        b_op_t      b_op;
        logic       areg_load;
        logic       key_load;
        logic       emit;
        emit_sel_t  emit_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic full;
        logic a_lt_b;
        logic a1_lt_cnt;
        logic b1_lt_cnt;
        logic key_eq;
        logic key_lt;
        logic swap;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/skts_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_in_if
// request channel: command, key and name with valid/ready
// ----------------------------------------------------------------------------
interface skts_in_if;
    import skts_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [WORD_W-1:0] key_in;
    logic [WORD_W-1:0] name_in;

    modport source (output valid, output cmd, output key_in, output name_in, input ready);
    modport sink   (input valid, input cmd, input key_in, input name_in, output ready);
endinterface
`default_nettype wire

// ===== sv/skts_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_out_if
// result channel: list entries and search answers with valid/ready
// ----------------------------------------------------------------------------
interface skts_out_if;
    import skts_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic              found;
    logic [WORD_W-1:0] key_out;
    logic [WORD_W-1:0] name_out;
    logic              last;

    modport source (output valid, output kind, output found, output key_out,
                    output name_out, output last, input ready);
    modport sink   (input valid, input kind, input found, input key_out,
                    input name_out, input last, output ready);
endinterface
`default_nettype wire

// ===== sv/sorted_key_table_search_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_search_core
// record table with in-place exchange sort, ordered listing and binary search
// ----------------------------------------------------------------------------
// usage
//   in_ch carries one request per handshake: cmd, key_in, name_in.
//   load (cmd 0) appends a key/name pair; a full table drops it.
//   sort (cmd 1) orders the table in place, then sends every entry on out_ch
//   with kind 0 and last on the final entry; an empty table sends nothing.
//   search (cmd 2) sends exactly one answer with kind 1, found and the name.
//   cmd 3 is dropped.
// sequencing
//   the table sits in a memory with one write and one registered read port,
//   so every record fetch is registered. a search alternates a range check
//   and a key compare per probe until a hit or an empty range, then
//   registers its answer. a sort compares each entry with every later one,
//   swapping as it goes, then lists the entries by read and emit steps.
//   in_ch.ready is high only while no request is in progress.
// reset and stall
//   reset empties the table (entry count zero) and the result register.
//   results pass through a one-entry output register; while out_ch stalls
//   the sequencer holds and resumes when the register is taken.
// ----------------------------------------------------------------------------
module sorted_key_table_search_core (
    input  wire logic clk,
    input  wire logic rst_n,
    skts_in_if.sink   in_ch,
    skts_out_if.source out_ch
);
    import skts_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;
    logic      in_ready;

    assign in_ch.ready = in_ready;

    // sequencer: decides fetch, compare, swap and emit per cycle
    skts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .in_cmd   (in_ch.cmd),
        .stat     (dp_stat),
        .cmd      (ctrl_cmd)
    );

    // table memory, indexes, comparators and output register
    skts_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctrl_cmd),
        .stat      (dp_stat),
        .key_in    (in_ch.key_in),
        .name_in   (in_ch.name_in),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .kind      (out_ch.kind),
        .found     (out_ch.found),
        .key_out   (out_ch.key_out),
        .name_out  (out_ch.name_out),
        .last      (out_ch.last)
    );

endmodule
`default_nettype wire

// ===== sv/skts_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_datapath
// record memory, index counters, key compare and result register
// ----------------------------------------------------------------------------
module skts_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire skts_pkg::ctrl_cmd_t        cmd,
    output skts_pkg::dp_stat_t              stat,
    input  wire logic [skts_pkg::WORD_W-1:0] key_in,
    input  wire logic [skts_pkg::WORD_W-1:0] name_in,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic                            kind,
    output logic                            found,
    output logic [skts_pkg::WORD_W-1:0]     key_out,
    output logic [skts_pkg::WORD_W-1:0]     name_out,
    output logic                            last
);
    import skts_pkg::*;

    localparam int REC_W = 2 * WORD_W;

    // key in the upper half, name in the lower half
    logic [REC_W-1:0] mem [TABLE_DEPTH];
    logic [REC_W-1:0] rd_data_reg;
    logic [REC_W-1:0] a_rec_reg;
    logic [WORD_W-1:0] search_key_reg;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] a_idx_reg, a_idx_next;
    logic [CNT_W-1:0] b_idx_reg, b_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic              kind_reg, found_reg, last_reg;
    logic [WORD_W-1:0] key_out_reg, name_out_reg;

    logic [CNT_W:0]   a_p1, b_p1, mid_sum;
    logic [CNT_W-1:0] mid;
    logic [IDX_W-1:0] waddr, raddr;
    logic [REC_W-1:0] wdata;
    logic [WORD_W-1:0] rd_key, rd_name, a_key;

    assign a_p1    = {1'b0, a_idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign b_p1    = {1'b0, b_idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    // only used while lo < hi+1, so the sum never goes negative
    assign mid_sum = {1'b0, a_idx_reg} + {1'b0, b_idx_reg} - {{CNT_W{1'b0}}, 1'b1};
    assign mid     = mid_sum[CNT_W:1];

    assign rd_key  = rd_data_reg[REC_W-1:WORD_W];
    assign rd_name = rd_data_reg[WORD_W-1:0];
    assign a_key   = a_rec_reg[REC_W-1:WORD_W];

    always_comb
    begin
        unique case (cmd.waddr_sel)
            WA_COUNT: waddr = count_reg[IDX_W-1:0];
            WA_A:     waddr = a_idx_reg[IDX_W-1:0];
            WA_B:     waddr = b_idx_reg[IDX_W-1:0];
            default:  waddr = count_reg[IDX_W-1:0];
        endcase
        unique case (cmd.wdata_sel)
            WD_IN:   wdata = {key_in, name_in};
            WD_AREG: wdata = a_rec_reg;
            default: wdata = a_rec_reg;
        endcase
        unique case (cmd.raddr_sel)
            RA_A:    raddr = a_idx_reg[IDX_W-1:0];
            RA_B:    raddr = b_idx_reg[IDX_W-1:0];
            RA_BP1:  raddr = b_p1[IDX_W-1:0];
            RA_MID:  raddr = mid[IDX_W-1:0];
            default: raddr = a_idx_reg[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
        end

        unique case (cmd.a_op)
            A_HOLD:  a_idx_next = a_idx_reg;
            A_ZERO:  a_idx_next = '0;
            A_INC:   a_idx_next = a_p1[CNT_W-1:0];
            A_MIDP1: a_idx_next = mid + {{(CNT_W-1){1'b0}}, 1'b1};
            default: a_idx_next = a_idx_reg;
        endcase

        unique case (cmd.b_op)
            B_HOLD:  b_idx_next = b_idx_reg;
            B_COUNT: b_idx_next = count_reg;
            B_AP1:   b_idx_next = a_p1[CNT_W-1:0];
            B_INC:   b_idx_next = b_p1[CNT_W-1:0];
            B_MID:   b_idx_next = mid;
            default: b_idx_next = b_idx_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            a_idx_reg     <= '0;
            b_idx_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            a_idx_reg     <= a_idx_next;
            b_idx_reg     <= b_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.areg_load)
        begin
            a_rec_reg <= rd_data_reg;
        end
        if (cmd.key_load)
        begin
            search_key_reg <= key_in;
        end
        if (cmd.emit)
        begin
            unique case (cmd.emit_sel)
                EMIT_LIST:
                begin
                    kind_reg     <= 1'b0;
                    found_reg    <= 1'b1;
                    key_out_reg  <= rd_key;
                    name_out_reg <= rd_name;
                    last_reg     <= ~(a_p1 < {1'b0, count_reg});
                end
                EMIT_HIT:
                begin
                    kind_reg     <= 1'b1;
                    found_reg    <= 1'b1;
                    key_out_reg  <= search_key_reg;
                    name_out_reg <= rd_name;
                    last_reg     <= 1'b1;
                end
                default:
                begin
                    kind_reg     <= 1'b1;
                    found_reg    <= 1'b0;
                    key_out_reg  <= search_key_reg;
                    name_out_reg <= '0;
                    last_reg     <= 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.full      = (count_reg == CNT_W'(TABLE_DEPTH));
    assign stat.a_lt_b    = (a_idx_reg < b_idx_reg);
    assign stat.a1_lt_cnt = (a_p1 < {1'b0, count_reg});
    assign stat.b1_lt_cnt = (b_p1 < {1'b0, count_reg});
    assign stat.key_eq    = (search_key_reg == rd_key);
    assign stat.key_lt    = (search_key_reg < rd_key);
    assign stat.swap      = (a_key > rd_key);
    assign stat.out_free  = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign found     = found_reg;
    assign key_out   = key_out_reg;
    assign name_out  = name_out_reg;
    assign last      = last_reg;

endmodule
`default_nettype wire

// ===== sv/skts_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skts_ctrl
// sequencer for load, exchange sort with listing, and binary search
// ----------------------------------------------------------------------------
module skts_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          in_cmd,
    input  wire skts_pkg::dp_stat_t  stat,
    output skts_pkg::ctrl_cmd_t      cmd
);
    import skts_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE      = 9'b000000001,
        ST_SRCH_CHK  = 9'b000000010,
        ST_SRCH_CMP  = 9'b000000100,
        ST_SORT_I    = 9'b000001000,
        ST_SORT_LDA  = 9'b000010000,
        ST_SORT_CMP  = 9'b000100000,
        ST_SORT_WRI  = 9'b001000000,
        ST_LIST_RD   = 9'b010000000,
        ST_LIST_EMIT = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.mem_we    = 1'b0;
        cmd.waddr_sel = WA_COUNT;
        cmd.wdata_sel = WD_IN;
        cmd.raddr_sel = RA_A;
        cmd.cnt_inc   = 1'b0;
        cmd.a_op      = A_HOLD;
        cmd.b_op      = B_HOLD;
        cmd.areg_load = 1'b0;
        cmd.key_load  = 1'b0;
        cmd.emit      = 1'b0;
        cmd.emit_sel  = EMIT_LIST;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    priority if (in_cmd == CMD_LOAD)
                    begin
                        if (!stat.full)
                        begin
                            cmd.mem_we  = 1'b1;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    else if (in_cmd == CMD_SORT)
                    begin
                        cmd.a_op   = A_ZERO;
                        state_next = ST_SORT_I;
                    end
                    else if (in_cmd == CMD_SEARCH)
                    begin
                        cmd.key_load = 1'b1;
                        cmd.a_op     = A_ZERO;
                        cmd.b_op     = B_COUNT;
                        state_next   = ST_SRCH_CHK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // lo in a, hi+1 in b
            ST_SRCH_CHK:
            begin
                cmd.raddr_sel = RA_MID;
                if (stat.a_lt_b)
                begin
                    state_next = ST_SRCH_CMP;
                end
                else if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_MISS;
                    state_next   = ST_IDLE;
                end
            end

            ST_SRCH_CMP:
            begin
                cmd.raddr_sel = RA_MID;
                if (stat.key_eq)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit     = 1'b1;
                        cmd.emit_sel = EMIT_HIT;
                        state_next   = ST_IDLE;
                    end
                end
                else if (stat.key_lt)
                begin
                    cmd.b_op   = B_MID;
                    state_next = ST_SRCH_CHK;
                end
                else
                begin
                    cmd.a_op   = A_MIDP1;
                    state_next = ST_SRCH_CHK;
                end
            end

            // outer index in a, inner index in b
            ST_SORT_I:
            begin
                if (stat.a1_lt_cnt)
                begin
                    cmd.raddr_sel = RA_A;
                    cmd.b_op      = B_AP1;
                    state_next    = ST_SORT_LDA;
                end
                else
                begin
                    cmd.a_op   = A_ZERO;
                    state_next = ST_LIST_RD;
                end
            end

            ST_SORT_LDA:
            begin
                cmd.areg_load = 1'b1;
                cmd.raddr_sel = RA_B;
                state_next    = ST_SORT_CMP;
            end

            ST_SORT_CMP:
            begin
                cmd.raddr_sel = RA_BP1;
                if (stat.swap)
                begin
                    cmd.mem_we    = 1'b1;
                    cmd.waddr_sel = WA_B;
                    cmd.wdata_sel = WD_AREG;
                    cmd.areg_load = 1'b1;
                end
                if (stat.b1_lt_cnt)
                begin
                    cmd.b_op = B_INC;
                end
                else
                begin
                    state_next = ST_SORT_WRI;
                end
            end

            ST_SORT_WRI:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = WA_A;
                cmd.wdata_sel = WD_AREG;
                cmd.a_op      = A_INC;
                state_next    = ST_SORT_I;
            end

            ST_LIST_RD:
            begin
                cmd.raddr_sel = RA_A;
                if (stat.a_lt_b)
                begin
                    state_next = ST_LIST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_LIST_EMIT:
            begin
                cmd.raddr_sel = RA_A;
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = EMIT_LIST;
                    cmd.a_op     = A_INC;
                    state_next   = ST_LIST_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // listing walks a up to the count held in b
        if (state_reg == ST_SORT_I && !stat.a1_lt_cnt)
        begin
            cmd.b_op = B_COUNT;
        end
    end

endmodule
`default_nettype wire
